[sv/cfp_pkg.sv]
// ----------------------------------------------------------------------------
// cfp_pkg
// types, character codes and helpers shared by the formula parser modules
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int NUM_ELEM     = 10;
  localparam int COUNT_W      = 7;
  localparam int ELEM_W       = 4;
  localparam int POS_W        = 8;
  localparam int MAX_CHARS_DEF = 33;

  localparam logic [ELEM_W-1:0] IDX_C    = 4'd0;
  localparam logic [ELEM_W-1:0] IDX_H    = 4'd1;
  localparam logic [ELEM_W-1:0] IDX_BR   = 4'd2;
  localparam logic [ELEM_W-1:0] IDX_CL   = 4'd3;
  localparam logic [ELEM_W-1:0] IDX_F    = 4'd4;
  localparam logic [ELEM_W-1:0] IDX_I    = 4'd5;
  localparam logic [ELEM_W-1:0] IDX_N    = 4'd6;
  localparam logic [ELEM_W-1:0] IDX_O    = 4'd7;
  localparam logic [ELEM_W-1:0] IDX_P    = 4'd8;
  localparam logic [ELEM_W-1:0] IDX_S    = 4'd9;
  localparam logic [ELEM_W-1:0] NO_ELEM  = 4'd10;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_L   = 8'h6c;
  localparam logic [7:0] CH_H   = 8'h48;
  localparam logic [7:0] CH_B   = 8'h42;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_F   = 8'h46;
  localparam logic [7:0] CH_I   = 8'h49;
  localparam logic [7:0] CH_N   = 8'h4e;
  localparam logic [7:0] CH_O   = 8'h4f;
  localparam logic [7:0] CH_P   = 8'h50;
  localparam logic [7:0] CH_S   = 8'h53;
  localparam logic [7:0] CH_D0  = 8'h30;
  localparam logic [7:0] CH_D9  = 8'h39;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_C    = 2'd1,
    PEND_B    = 2'd2
  } pend_t;

  typedef logic [NUM_ELEM-1:0][COUNT_W-1:0] counts_t;

  typedef struct packed {
    counts_t            counts;
    pend_t              pend;
    logic [ELEM_W-1:0]  cur;
    logic [1:0]         digits;
    logic [3:0]         first;
    logic [POS_W-1:0]   pos;
  } cfp_state_t;

  typedef struct packed {
    counts_t counts;
    logic    cut_short;
  } cfp_result_t;

  localparam cfp_state_t STATE_RST = '{
    counts: '0,
    pend:   PEND_NONE,
    cur:    NO_ELEM,
    digits: 2'd0,
    first:  4'd0,
    pos:    '0
  };

  function automatic cfp_state_t start_elem(cfp_state_t s, logic [ELEM_W-1:0] idx);
    cfp_state_t t;
    t = s;
    t.counts[idx] = 7'd1;
    t.cur = idx;
    t.digits = 2'd0;
    return t;
  endfunction

  function automatic cfp_state_t settle(cfp_state_t s);
    cfp_state_t t;
    t = s;
    if (s.pend == PEND_C) begin
      t = start_elem(s, IDX_C);
    end
    t.pend = PEND_NONE;
    return t;
  endfunction

endpackage

[sv/cfp_step.sv]
// ----------------------------------------------------------------------------
// cfp_step
// next-state and result logic for one formula character
// ----------------------------------------------------------------------------
module cfp_step #(
  parameter int MAX_CHARS = cfp_pkg::MAX_CHARS_DEF
) (
  input  cfp_pkg::cfp_state_t  state_i,
  input  logic [7:0]           char_code,
  output cfp_pkg::cfp_state_t  state_o,
  output logic                 res_valid,
  output cfp_pkg::cfp_result_t res_o
);
  import cfp_pkg::*;

  always_comb begin
    cfp_state_t        s;
    logic              done;
    logic [COUNT_W-1:0] two;
    s = state_i;
    done = 1'b0;
    res_valid = 1'b0;
    res_o = '0;
    two = 7'(s.first) * 7'd10 + 7'(char_code[3:0]);

    if (s.pend == PEND_C && char_code == CH_L) begin
      s.pend = PEND_NONE;
      s = start_elem(s, IDX_CL);
    end else if (s.pend == PEND_B && char_code == CH_R) begin
      s.pend = PEND_NONE;
      s = start_elem(s, IDX_BR);
    end else begin
      s = settle(s);
      if (char_code == CH_NUL) begin
        res_valid = 1'b1;
        res_o.counts = s.counts;
        res_o.cut_short = 1'b0;
        s = STATE_RST;
        done = 1'b1;
      end else begin
        case (char_code)
          CH_H: s = start_elem(s, IDX_H);
          CH_F: s = start_elem(s, IDX_F);
          CH_I: s = start_elem(s, IDX_I);
          CH_N: s = start_elem(s, IDX_N);
          CH_O: s = start_elem(s, IDX_O);
          CH_P: s = start_elem(s, IDX_P);
          CH_S: s = start_elem(s, IDX_S);
          CH_C: begin
            s.cur = NO_ELEM;
            s.digits = 2'd0;
            s.pend = PEND_C;
          end
          CH_B: begin
            s.cur = NO_ELEM;
            s.digits = 2'd0;
            s.pend = PEND_B;
          end
          default: begin
            if (char_code >= CH_D0 && char_code <= CH_D9) begin
              if (s.cur < NO_ELEM) begin
                if (s.digits == 2'd0) begin
                  s.counts[s.cur] = 7'(char_code[3:0]);
                  s.first = char_code[3:0];
                  s.digits = 2'd1;
                end else if (s.digits == 2'd1) begin
                  s.counts[s.cur] = two;
                  s.digits = 2'd2;
                end
              end
            end else begin
              s.cur = NO_ELEM;
              s.digits = 2'd0;
            end
          end
        endcase
      end
    end

    if (!done) begin
      s.pos = s.pos + 8'd1;
      if (s.pos >= POS_W'(MAX_CHARS)) begin
        s = settle(s);
        res_valid = 1'b1;
        res_o.counts = s.counts;
        res_o.cut_short = 1'b1;
        s = STATE_RST;
      end
    end
    state_o = s;
  end

endmodule

[sv/cfp_out_buf.sv]
// ----------------------------------------------------------------------------
// cfp_out_buf
// result register with a skid slot so input keeps flowing under stall
// ----------------------------------------------------------------------------
module cfp_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  cfp_pkg::cfp_result_t load_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output cfp_pkg::cfp_result_t out_data,
  output logic                 full
);
  import cfp_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  cfp_result_t out_data_r, out_data_nxt;
  cfp_result_t skid_data_r, skid_data_nxt;
  logic        out_free;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt = skid_data_r;
        skid_valid_nxt = load;
        skid_data_nxt = load_data;
      end else begin
        out_valid_nxt = load;
        out_data_nxt = load_data;
      end
    end else if (load) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign full = skid_valid_r;

endmodule

[sv/chemical_formula_parser_core.sv]
// ----------------------------------------------------------------------------
// chemical_formula_parser_core
// streaming molecular formula reader: one character per beat, ten atom
// counts out at a zero byte or at the character limit
// result: an ending character beat loads its result into the result register or skid slot
// throughput: one character beat per cycle while in_stall is low, set by the single state register
// input stalls only while the result register and its skid slot are both full
// reset: synchronous active-low rst_n clears counts, parser state and buffers
// ----------------------------------------------------------------------------
module chemical_formula_parser_core #(
  parameter int MAX_CHARS = cfp_pkg::MAX_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cfp_pkg::COUNT_W-1:0] out_carbon_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_hydrogen_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_bromine_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_chlorine_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_fluorine_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_iodine_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_nitrogen_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_oxygen_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_phosphorus_count,
  output logic [cfp_pkg::COUNT_W-1:0] out_sulfur_count,
  output logic                        out_cut_short
);
  import cfp_pkg::*;

  cfp_state_t  state_r, state_nxt, step_state;
  cfp_result_t step_res, out_data;
  logic        step_valid;
  logic        in_fire;
  logic        buf_full;

  assign in_fire = in_valid && !in_stall;
  assign in_stall = buf_full;

  cfp_step #(
    .MAX_CHARS(MAX_CHARS)
  ) u_step (
    .state_i   (state_r),
    .char_code (in_char_code),
    .state_o   (step_state),
    .res_valid (step_valid),
    .res_o     (step_res)
  );

  assign state_nxt = in_fire ? step_state : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  cfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && step_valid),
    .load_data (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  assign out_carbon_count     = out_data.counts[IDX_C];
  assign out_hydrogen_count   = out_data.counts[IDX_H];
  assign out_bromine_count    = out_data.counts[IDX_BR];
  assign out_chlorine_count   = out_data.counts[IDX_CL];
  assign out_fluorine_count   = out_data.counts[IDX_F];
  assign out_iodine_count     = out_data.counts[IDX_I];
  assign out_nitrogen_count   = out_data.counts[IDX_N];
  assign out_oxygen_count     = out_data.counts[IDX_O];
  assign out_phosphorus_count = out_data.counts[IDX_P];
  assign out_sulfur_count     = out_data.counts[IDX_S];
  assign out_cut_short        = out_data.cut_short;

  a_pos_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos < POS_W'(MAX_CHARS))
    else $error("character position reached the limit without a result");

  a_result_registered: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_valid) |=> out_valid)
    else $error("ending character beat did not produce a result beat");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("skid slot holds a beat while the result register is empty");

  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cur <= NO_ELEM)
    else $error("current element index out of range");

endmodule

[dv/tb_chemical_formula_parser_core.sv]
// ----------------------------------------------------------------------------
// tb_chemical_formula_parser_core
// drives formula characters into the parser one beat at a time, with random
// gaps on the sender and random stalls on the receiver, and tracks the atom
// tallies in its own copy of the parser so that every result beat is checked
// field by field against the next expected tally
// ----------------------------------------------------------------------------
module tb_chemical_formula_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cfp_pkg::*;

  localparam int FORMULA_LIMIT = MAX_CHARS_DEF;
  localparam int RANDOM_CHARS  = 2000;
  localparam int IDLE_PCT      = 18;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COUNT_W-1:0] out_carbon_count;
  logic [COUNT_W-1:0] out_hydrogen_count;
  logic [COUNT_W-1:0] out_bromine_count;
  logic [COUNT_W-1:0] out_chlorine_count;
  logic [COUNT_W-1:0] out_fluorine_count;
  logic [COUNT_W-1:0] out_iodine_count;
  logic [COUNT_W-1:0] out_nitrogen_count;
  logic [COUNT_W-1:0] out_oxygen_count;
  logic [COUNT_W-1:0] out_phosphorus_count;
  logic [COUNT_W-1:0] out_sulfur_count;
  logic out_cut_short;

  chemical_formula_parser_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_char_code         (in_char_code),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_carbon_count     (out_carbon_count),
    .out_hydrogen_count   (out_hydrogen_count),
    .out_bromine_count    (out_bromine_count),
    .out_chlorine_count   (out_chlorine_count),
    .out_fluorine_count   (out_fluorine_count),
    .out_iodine_count     (out_iodine_count),
    .out_nitrogen_count   (out_nitrogen_count),
    .out_oxygen_count     (out_oxygen_count),
    .out_phosphorus_count (out_phosphorus_count),
    .out_sulfur_count     (out_sulfur_count),
    .out_cut_short        (out_cut_short)
  );

  always #5 clk = ~clk;

  // parser shadow state
  counts_t           tally;
  pend_t             held_letter = PEND_NONE;
  logic [ELEM_W-1:0] digit_target = NO_ELEM;
  logic [1:0]        digit_cnt = 2'd0;
  logic [3:0]        lead_digit = 4'd0;
  logic [POS_W-1:0]  char_pos = '0;

  logic [7:0]  formula_chars[$];
  cfp_result_t expected_tallies[$];

  int   errors = 0;
  int   beats_sent = 0;
  int   cycle_cnt = 0;
  bit   char_taken = 1'b0;
  bit   hold_results = 1'b0;

  string count_name[NUM_ELEM] = '{"carbon_count", "hydrogen_count", "bromine_count",
    "chlorine_count", "fluorine_count", "iodine_count", "nitrogen_count",
    "oxygen_count", "phosphorus_count", "sulfur_count"};
  string symbols[NUM_ELEM] = '{"C", "H", "Br", "Cl", "F", "I", "N", "O", "P", "S"};

  initial tally = '0;

  function automatic void open_elem(logic [ELEM_W-1:0] idx);
    tally[idx] = 7'd1;
    digit_target = idx;
    digit_cnt = 2'd0;
  endfunction

  function automatic void stop_digits();
    digit_target = NO_ELEM;
    digit_cnt = 2'd0;
  endfunction

  function automatic void resolve_letter();
    if (held_letter == PEND_C) begin
      open_elem(IDX_C);
    end
    held_letter = PEND_NONE;
  endfunction

  function automatic cfp_result_t close_formula(logic cut);
    cfp_result_t res;
    res.counts = tally;
    res.cut_short = cut;
    tally = '0;
    held_letter = PEND_NONE;
    stop_digits();
    lead_digit = 4'd0;
    char_pos = '0;
    return res;
  endfunction

  function automatic bit parse_char(input logic [7:0] c, output cfp_result_t res);
    bit joined;
    logic [3:0] d;
    joined = 1'b0;
    res = '0;
    if (held_letter == PEND_C && c == CH_L) begin
      held_letter = PEND_NONE;
      open_elem(IDX_CL);
      joined = 1'b1;
    end else if (held_letter == PEND_B && c == CH_R) begin
      held_letter = PEND_NONE;
      open_elem(IDX_BR);
      joined = 1'b1;
    end else begin
      resolve_letter();
    end
    if (!joined) begin
      if (c == CH_NUL) begin
        res = close_formula(1'b0);
        return 1'b1;
      end
      case (c)
        CH_H: open_elem(IDX_H);
        CH_F: open_elem(IDX_F);
        CH_I: open_elem(IDX_I);
        CH_N: open_elem(IDX_N);
        CH_O: open_elem(IDX_O);
        CH_P: open_elem(IDX_P);
        CH_S: open_elem(IDX_S);
        CH_C: begin
          stop_digits();
          held_letter = PEND_C;
        end
        CH_B: begin
          stop_digits();
          held_letter = PEND_B;
        end
        default: begin
          if (c >= CH_D0 && c <= CH_D9) begin
            d = 4'(c - CH_D0);
            if (digit_target < NUM_ELEM) begin
              if (digit_cnt == 2'd0) begin
                tally[digit_target] = 7'(d);
                lead_digit = d;
                digit_cnt = 2'd1;
              end else if (digit_cnt == 2'd1) begin
                tally[digit_target] = 7'(lead_digit * 10 + d);
                digit_cnt = 2'd2;
              end
            end
          end else begin
            stop_digits();
          end
        end
      endcase
    end
    char_pos = char_pos + 1'b1;
    if (char_pos >= FORMULA_LIMIT) begin
      resolve_letter();
      res = close_formula(1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      formula_chars.push_back(8'(s[i]));
    end
  endtask

  task automatic add_formula();
    int target;
    int flen;
    int pick;
    target = ($urandom_range(0, 99) < 15) ? $urandom_range(FORMULA_LIMIT - 3, FORMULA_LIMIT + 12)
                                           : $urandom_range(1, 20);
    flen = 0;
    while (flen < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        push_text(symbols[$urandom_range(0, NUM_ELEM - 1)]);
        flen += 1;
        repeat ($urandom_range(0, 3)) begin
          formula_chars.push_back(8'(CH_D0 + $urandom_range(0, 9)));
          flen += 1;
        end
      end else begin
        case ($urandom_range(0, 4))
          0: formula_chars.push_back(8'($urandom_range(1, 255)));
          1: formula_chars.push_back(8'($urandom_range(0, 255)));
          2: formula_chars.push_back(($urandom_range(0, 1) != 0) ? CH_L : CH_R);
          3: formula_chars.push_back(CH_B);
          default: formula_chars.push_back(8'(CH_D0 + $urandom_range(0, 9)));
        endcase
        flen += 1;
      end
    end
    if (flen < FORMULA_LIMIT || $urandom_range(0, 1) != 0) begin
      formula_chars.push_back(CH_NUL);
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || char_taken) begin
      char_taken = 1'b0;
      if (formula_chars.size() != 0 &&
          ((beats_sent >= 900 && beats_sent < 1200) || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_char_code <= formula_chars.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_results ||
                   (!(cycle_cnt >= 1300 && cycle_cnt < 1700) &&
                    $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // long receiver hold so the result buffer fills and input stalls
  initial begin
    wait (beats_sent >= 300);
    @(posedge clk);
    hold_results = 1'b1;
    repeat (300) @(posedge clk);
    hold_results = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    cfp_result_t res;
    cfp_result_t want;
    counts_t got;
    if (rst_n) begin
      cycle_cnt++;
      if (in_valid && !in_stall) begin
        char_taken = 1'b1;
        beats_sent++;
        if (parse_char(in_char_code, res)) begin
          expected_tallies.push_back(res);
        end
      end
      if (out_valid && !out_stall) begin
        got[IDX_C]  = out_carbon_count;
        got[IDX_H]  = out_hydrogen_count;
        got[IDX_BR] = out_bromine_count;
        got[IDX_CL] = out_chlorine_count;
        got[IDX_F]  = out_fluorine_count;
        got[IDX_I]  = out_iodine_count;
        got[IDX_N]  = out_nitrogen_count;
        got[IDX_O]  = out_oxygen_count;
        got[IDX_P]  = out_phosphorus_count;
        got[IDX_S]  = out_sulfur_count;
        if (expected_tallies.size() == 0) begin
          $error("result beat with no formula ended");
          errors++;
        end else begin
          want = expected_tallies.pop_front();
          for (int k = 0; k < NUM_ELEM; k++) begin
            if (got[k] !== want.counts[k]) begin
              $error("%s expected %0d got %0d", count_name[k], want.counts[k], got[k]);
              errors++;
            end
          end
          if (out_cut_short !== want.cut_short) begin
            $error("cut_short expected %0d got %0d", want.cut_short, out_cut_short);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int base;
    formula_chars.push_back(CH_NUL);
    push_text("9C05C0Cl123BxBr9r");
    formula_chars.push_back(8'hff);
    push_text("lHC");
    formula_chars.push_back(CH_NUL);
    push_text("B");
    formula_chars.push_back(CH_NUL);
    base = formula_chars.size();
    while (formula_chars.size() < base + RANDOM_CHARS) begin
      add_formula();
    end
    formula_chars.push_back(CH_NUL);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (formula_chars.size() != 0 || in_valid) @(posedge clk);
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
